// ----- hdl/set_assoc_cache_lru_tags_unit_assert.svh -----
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags_unit assertion macros
// shared property wrappers, clocked on clock and quiet during reset
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_TAGS_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_TAGS_UNIT_ASSERT_SVH

// same-cycle implication
`define SACL_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sacl same-cycle check failed");

// next-cycle implication
`define SACL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sacl next-cycle check failed");

`endif

// ----- hdl/sacl_pkg.sv -----
// ----------------------------------------------------------------------------
// sacl_pkg
// sizes, line record and controller/datapath command and status types
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int NUM_SETS         = 64;
   localparam int BLOCK_BYTES      = 32;
   localparam int NUM_WAYS_DEFAULT = 4;

   localparam int ADDR_W    = 32;
   localparam int OFFSET_W  = $clog2(BLOCK_BYTES);
   localparam int SET_W     = $clog2(NUM_SETS);
   localparam int TAG_W     = ADDR_W - OFFSET_W - SET_W;
   localparam int STAMP_W   = 32;
   localparam int WAY_OUT_W = 2;

   typedef enum logic {
      REQ_READ  = 1'b0,
      REQ_WRITE = 1'b1
   } access_type;

   typedef struct packed {
      logic               dirty;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
   } line_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic resolved;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

// ----- hdl/sacl_if.sv -----
// ----------------------------------------------------------------------------
// sacl channel interfaces
// valid/ready channels for access requests and lookup responses
// ----------------------------------------------------------------------------
interface sacl_req_if
   import sacl_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output req_type, output address, input ready);
   modport sink (input valid, input req_type, input address, output ready);
endinterface

interface sacl_rsp_if
   import sacl_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [WAY_OUT_W-1:0] way_used;
   logic                 writeback;

   modport source (output valid, output hit, output way_used, output writeback, input ready);
   modport sink (input valid, input hit, input way_used, input writeback, output ready);
endinterface

// ----- hdl/sacl_ctrl.sv -----
// ----------------------------------------------------------------------------
// sacl_ctrl
// access sequencer: lookup, optional lru scan, fill and response handoff
// ----------------------------------------------------------------------------
module sacl_ctrl
   import sacl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      IDLE,
      LOOK,
      SCAN,
      FILL
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = LOOK;
            end
         end
         LOOK: begin
            if (status.resolved) begin
               if (status.out_free) begin
                  cmd.commit = 1'b1;
                  state_in   = IDLE;
               end
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = SCAN;
            end
         end
         SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = FILL;
            end
         end
         FILL: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      ready_in = (state_in == IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

// ----- hdl/sacl_dpath.sv -----
// ----------------------------------------------------------------------------
// sacl_dpath
// line memory, valid bits, hit and victim logic, lru scan, response register
// ----------------------------------------------------------------------------
module sacl_dpath
   import sacl_pkg::*;
#(
   parameter int NUM_WAYS = NUM_WAYS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_type,
   input  logic [ADDR_W-1:0]    address,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output logic [WAY_OUT_W-1:0] rsp_way_used,
   output logic                 rsp_writeback
);

   localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

   line_type line_mem [NUM_SETS][NUM_WAYS];
   line_type row_ff [NUM_WAYS];

   logic [NUM_WAYS-1:0] valid_ff [NUM_SETS];
   logic [NUM_WAYS-1:0] vrow;

   logic               write_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic [SET_W-1:0]   set_ff;
   logic [SET_W-1:0]   req_set;
   logic [TAG_W-1:0]   req_tag;
   logic [STAMP_W-1:0] counter_ff;

   logic [WAY_W-1:0]   best_way_ff;
   logic [STAMP_W-1:0] best_stamp_ff;
   logic [WAY_W-1:0]   scan_idx_ff;
   logic [STAMP_W-1:0] cand_stamp;

   logic               hit;
   logic               free;
   logic [WAY_W-1:0]   hit_way;
   logic [WAY_W-1:0]   free_way;
   logic [WAY_W-1:0]   commit_way;
   line_type           sel_line;
   line_type           new_line;
   logic               wb;

   logic                 rsp_valid_ff;
   logic                 hit_ff;
   logic [WAY_OUT_W-1:0] way_ff;
   logic                 wb_ff;

   assign req_set = address[OFFSET_W +: SET_W];
   assign req_tag = address[ADDR_W-1 -: TAG_W];
   assign vrow    = valid_ff[set_ff];

   // lowest matching way and lowest free way
   always_comb begin
      hit      = 1'b0;
      free     = 1'b0;
      hit_way  = '0;
      free_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (vrow[w] && (row_ff[w].tag == tag_ff)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!vrow[w]) begin
            free     = 1'b1;
            free_way = WAY_W'(w);
         end
      end
   end

   assign status.resolved  = hit || free || (NUM_WAYS == 1);
   assign status.scan_last = (scan_idx_ff == WAY_W'(NUM_WAYS - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign commit_way = status.resolved ? (hit ? hit_way : free_way) : best_way_ff;
   assign sel_line   = row_ff[commit_way];
   assign cand_stamp = row_ff[scan_idx_ff].stamp;

   always_comb begin
      new_line.dirty = hit ? (sel_line.dirty || write_ff) : write_ff;
      new_line.tag   = tag_ff;
      new_line.stamp = counter_ff;
   end

   assign wb = !hit && vrow[commit_way] && sel_line.dirty;

   // line memory: one row read per access, one line written back
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            row_ff[w] <= line_mem[req_set][w];
         end
      end
      if (cmd.commit) begin
         line_mem[set_ff][commit_way] <= new_line;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         write_ff <= (access_type'(req_type) == REQ_WRITE);
         tag_ff   <= req_tag;
         set_ff   <= req_set;
      end
      if (cmd.scan_start) begin
         best_way_ff   <= '0;
         best_stamp_ff <= row_ff[0].stamp;
         scan_idx_ff   <= WAY_W'(1);
      end else if (cmd.scan_step) begin
         if (cand_stamp < best_stamp_ff) begin
            best_way_ff   <= scan_idx_ff;
            best_stamp_ff <= cand_stamp;
         end
         scan_idx_ff <= scan_idx_ff + WAY_W'(1);
      end
      if (cmd.commit) begin
         hit_ff <= hit;
         way_ff <= WAY_OUT_W'(commit_way);
         wb_ff  <= wb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SETS; s++) begin
            valid_ff[s] <= '0;
         end
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            valid_ff[set_ff][commit_way] <= 1'b1;
            counter_ff                   <= counter_ff + STAMP_W'(1);
            rsp_valid_ff                 <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = hit_ff;
   assign rsp_way_used  = way_ff;
   assign rsp_writeback = wb_ff;

endmodule

// ----- hdl/set_assoc_cache_lru_tags_unit.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags_unit
// lru tag store of a set-associative write-back write-allocate cache
//
//   channel   dir  beat contents
//   req_chan  in   req_type, address
//   rsp_chan  out  hit, way_used, writeback
//
// hit or miss into a free way: row read, then update
// miss into a full set: row read, lru scan at one way per cycle, then update
// reset clears valid bits and the access counter together, no sweep
// the next request is taken while a response beat waits on rsp_chan
// a stalled response holds the update step until the response register frees
// ----------------------------------------------------------------------------
`include "set_assoc_cache_lru_tags_unit_assert.svh"

module set_assoc_cache_lru_tags_unit
   import sacl_pkg::*;
#(
   parameter int NUM_WAYS = NUM_WAYS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   sacl_req_if.sink    req_chan,
   sacl_rsp_if.source  rsp_chan
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   sacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sacl_dpath #(
      .NUM_WAYS (NUM_WAYS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_type      (req_chan.req_type),
      .address       (req_chan.address),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_hit       (rsp_chan.hit),
      .rsp_way_used  (rsp_chan.way_used),
      .rsp_writeback (rsp_chan.writeback)
   );

   assign req_chan.ready = req_ready;

   `SACL_ASSERT_NEXT(a_busy_after_accept, req_chan.valid && req_ready, !req_ready)
   `SACL_ASSERT_SAME(a_commit_slot_free, cmd.commit, !rsp_chan.valid || rsp_chan.ready)
   `SACL_ASSERT_SAME(a_rsp_from_commit, $rose(rsp_chan.valid), $past(cmd.commit))

endmodule
